FILE: rtl/core/phbt_pkg.sv
package phbt_pkg;

  parameter int unsigned MaxBouncesDef    = 1000;
  parameter int unsigned ExpTableDepthDef = 1024;

  // Widths fixed by the beat formats.
  parameter int unsigned BestW = 30;
  parameter int unsigned DvsW  = 25;
  parameter int unsigned CfgW  = 20;

  typedef enum logic [2:0] {
    ST_LAUNCHED  = 3'd0,
    ST_REFLECTED = 3'd1,
    ST_ABSORBED  = 3'd2,
    ST_DETECTED  = 3'd3,
    ST_ESCAPED   = 3'd4,
    ST_LIMIT     = 3'd5,
    ST_IDLE      = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    REG_LEN = 3'd0,
    REG_WID = 3'd1,
    REG_THK = 3'd2,
    REG_RAD = 3'd3,
    REG_NSC = 3'd4,
    REG_ATT = 3'd5,
    REG_TIR = 3'd6,
    REG_COS = 3'd7
  } reg_idx_e;

  parameter logic [2:0] WallXPos = 3'd0;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [15:0] abs17(input logic signed [16:0] v);
    logic [16:0] m;
    m = v[16] ? 17'(-v) : 17'(v);
    return m[15:0];
  endfunction

endpackage

FILE: rtl/core/photon_box_bounce_tracer_core.sv
// Traces one photon through an axis-aligned box. A launch beat (tuser 0) loads position and
// direction and answers without divider or multiplier work; a step beat (tuser 1) moves the
// photon to the nearest wall and decides absorption, detection, escape, reflection or the
// bounce limit, and answers idle when no photon is in flight. Each step of a photon in flight
// runs one shared restoring divider, one quotient bit per cycle, for each of up to three wall
// distances and, once a wall is found, for the absorption table index, plus shared multiplier
// and table work. The input is not ready while a beat is being worked on; a finished result
// waits in the output register while the next beat is taken.
module photon_box_bounce_tracer_core #(
  parameter int unsigned MAX_BOUNCES     = phbt_pkg::MaxBouncesDef,
  parameter int unsigned EXP_TABLE_DEPTH = phbt_pkg::ExpTableDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // start_x, start_y, start_z, heading_x, heading_y, heading_z, uniform_sample
  input  logic [111:0]              s_axis_tdata,
  // mode
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // arrival_time, bounces_done, wall_index, zero fill
  output logic [47:0]               m_axis_tdata,
  // status
  output logic [2:0]                m_axis_tuser,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [phbt_pkg::CfgW-1:0] cfg_data_i
);
  import phbt_pkg::*;

  localparam int unsigned IdxW = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned DvdW = BestW + IdxW;
  localparam int unsigned CntW = $clog2(DvdW + 1);

  localparam logic [63:0] ExpDen = 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0] ExpT0  = 64'd1 << 58;
  localparam logic [63:0] ExpT1  = (ExpT0 * 64'd16) / (ExpDen * 64'd1);
  localparam logic [63:0] ExpT2  = (ExpT1 * 64'd16) / (ExpDen * 64'd2);
  localparam logic [63:0] ExpT3  = (ExpT2 * 64'd16) / (ExpDen * 64'd3);
  localparam logic [63:0] ExpT4  = (ExpT3 * 64'd16) / (ExpDen * 64'd4);
  localparam logic [63:0] ExpT5  = (ExpT4 * 64'd16) / (ExpDen * 64'd5);
  localparam logic [63:0] ExpT6  = (ExpT5 * 64'd16) / (ExpDen * 64'd6);
  localparam logic [63:0] ExpT7  = (ExpT6 * 64'd16) / (ExpDen * 64'd7);
  localparam logic [63:0] ExpT8  = (ExpT7 * 64'd16) / (ExpDen * 64'd8);
  localparam logic [63:0] ExpT9  = (ExpT8 * 64'd16) / (ExpDen * 64'd9);
  localparam logic [63:0] ExpT10 = (ExpT9 * 64'd16) / (ExpDen * 64'd10);
  localparam logic [63:0] ExpT11 = (ExpT10 * 64'd16) / (ExpDen * 64'd11);
  localparam logic [63:0] ExpT12 = (ExpT11 * 64'd16) / (ExpDen * 64'd12);
  localparam logic [63:0] ExpT13 = (ExpT12 * 64'd16) / (ExpDen * 64'd13);
  localparam logic [63:0] ExpT14 = (ExpT13 * 64'd16) / (ExpDen * 64'd14);
  localparam logic [63:0] ExpT15 = (ExpT14 * 64'd16) / (ExpDen * 64'd15);
  localparam logic [63:0] ExpT16 = (ExpT15 * 64'd16) / (ExpDen * 64'd16);
  localparam logic [63:0] ExpT17 = (ExpT16 * 64'd16) / (ExpDen * 64'd17);
  localparam logic [63:0] ExpT18 = (ExpT17 * 64'd16) / (ExpDen * 64'd18);
  localparam logic [63:0] ExpT19 = (ExpT18 * 64'd16) / (ExpDen * 64'd19);
  localparam logic [63:0] ExpT20 = (ExpT19 * 64'd16) / (ExpDen * 64'd20);
  localparam logic [63:0] ExpSum = ExpT0 - ExpT1 + ExpT2 - ExpT3 + ExpT4 - ExpT5 + ExpT6
                                   - ExpT7 + ExpT8 - ExpT9 + ExpT10 - ExpT11 + ExpT12
                                   - ExpT13 + ExpT14 - ExpT15 + ExpT16 - ExpT17 + ExpT18
                                   - ExpT19 + ExpT20;
  localparam logic [63:0] ExpF30 = (ExpSum + (64'd1 << 27)) >> 28;

  typedef logic [16:0] exp_rom_t [EXP_TABLE_DEPTH];

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    tab;
    logic [63:0] v;
    v = 64'd1 << 30;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      tab[k] = 17'((v + (64'd1 << 13)) >> 14);
      v      = (v * ExpF30 + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam exp_rom_t ExpRom = build_exp_rom();

  typedef enum logic [4:0] {
    S_IDLE, S_AXIS, S_DIV_AX, S_CHK, S_MOV_W, S_MOV_U, S_TIME_W, S_TIME_U,
    S_IDX_W, S_IDX_U, S_DIV_IX, S_ROM_W, S_SURV, S_SQY_W, S_SQY_U, S_SQZ_W,
    S_SQZ_U, S_SQR_W, S_SQR_U, S_TIR, S_EMIT
  } state_e;

  state_e state_q;

  logic [15:0] len_q, wid_q, thk_q, rad_q, nsc_q;
  logic [19:0] att_q;
  logic        tir_q;
  logic [14:0] cos_q;

  logic signed [16:0] pos_q [3];
  logic signed [15:0] dir_q [3];
  logic [31:0]        flight_q;
  logic [9:0]         bounce_q;
  logic               active_q;

  logic [15:0]      sample_q;
  logic [1:0]       ax_q;
  logic [1:0]       axis_sel_q;
  logic             found_q;
  logic [BestW-1:0] best_q;
  logic [2:0]       wall_q;
  logic             idx_ok_q;
  logic [IdxW-1:0]  rom_addr_q;
  logic [16:0]      rom_q;
  logic [32:0]      acc_q;
  status_e          res_status_q;
  logic [2:0]       res_wall_q;

  logic [BestW-1:0] mul_a_q;
  logic [15:0]      mul_b_q;
  logic [45:0]      prod_q;

  logic [DvsW-1:0]  dv_rem_q;
  logic [DvdW-1:0]  dv_quo_q;
  logic [DvsW-1:0]  dv_dvs_q;
  logic [CntW-1:0]  dv_cnt_q;

  logic            m_valid_q;
  logic [2:0]      m_status_q;
  logic [31:0]     m_time_q;
  logic [9:0]      m_bounce_q;
  logic [2:0]      m_wall_q;
  logic            emit_fire;

  // Divider step.
  logic [DvsW:0]   dv_sh;
  logic            dv_ge;
  logic [DvsW-1:0] dv_rem_d;
  logic [DvdW-1:0] dv_quo_d;

  always_comb begin
    dv_sh    = {dv_rem_q, dv_quo_q[DvdW-1]};
    dv_ge    = dv_sh >= {1'b0, dv_dvs_q};
    dv_rem_d = dv_ge ? DvsW'(dv_sh - {1'b0, dv_dvs_q}) : dv_sh[DvsW-1:0];
    dv_quo_d = {dv_quo_q[DvdW-2:0], dv_ge};
  end

  // Wall geometry for the axis under work.
  logic signed [15:0] dir_a;
  logic signed [16:0] pos_a;
  logic signed [17:0] hi_a, wall_c, span;
  logic               ax_ok;
  logic [15:0]        mag, dm;
  logic [2:0]         wall_code;

  always_comb begin
    dir_a = dir_q[ax_q];
    pos_a = pos_q[ax_q];
    case (ax_q)
      2'd0:    hi_a = {2'b00, len_q};
      2'd1:    hi_a = {3'b000, wid_q[15:1]};
      default: hi_a = {3'b000, thk_q[15:1]};
    endcase
    if (!dir_a[15]) wall_c = hi_a;
    else if (ax_q == 2'd0) wall_c = '0;
    else wall_c = -hi_a;
    span      = wall_c - 18'(pos_a);
    ax_ok     = (dir_a != '0) && (dir_a[15] ? span < 0 : span > 0);
    mag       = span[17] ? 16'(-span) : 16'(span);
    dm        = abs16(dir_a);
    wall_code = {ax_q, dir_a[15]};
  end

  // Coordinate update after the flight.
  logic signed [33:0] mv_sum;
  logic signed [16:0] mv_new;

  always_comb begin
    if (dir_a[15]) mv_sum = 34'(pos_a) - $signed({2'b00, prod_q[45:14]});
    else mv_sum = 34'(pos_a) + $signed({2'b00, prod_q[45:14]});
    if (ax_q == axis_sel_q) mv_new = 17'(wall_c);
    else if (ax_q == 2'd0) begin
      if (mv_sum < 0) mv_new = '0;
      else if (mv_sum > 34'sd65535) mv_new = 17'sd65535;
      else mv_new = 17'(mv_sum);
    end else begin
      if (mv_sum < -34'sd32768) mv_new = -17'sd32768;
      else if (mv_sum > 34'sd32767) mv_new = 17'sd32767;
      else mv_new = 17'(mv_sum);
    end
  end

  logic [36:0]      time_sum;
  logic [19:0]      att_eff;
  logic [BestW-1:0] t_new;
  logic [16:0]      surv;
  logic [9:0]       bounce_inc;
  logic signed [15:0] dir_sel, dir_ref;

  always_comb begin
    time_sum   = {5'b0, flight_q} + {1'b0, prod_q[45:10]};
    att_eff    = (att_q == '0) ? 20'd1 : att_q;
    t_new      = dv_quo_d[BestW-1:0];
    surv       = idx_ok_q ? rom_q : '0;
    bounce_inc = bounce_q + 10'd1;
    dir_sel    = dir_q[axis_sel_q];
    dir_ref    = (dir_sel == -16'sd32768) ? 16'sd32767 : -dir_sel;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_q * mul_b_q;
    rom_q  <= ExpRom[rom_addr_q];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {3'b000, m_wall_q, m_bounce_q, m_time_q};
  assign emit_fire     = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      len_q        <= 16'd40960;
      wid_q        <= 16'd20480;
      thk_q        <= 16'd1024;
      rad_q        <= 16'd2560;
      nsc_q        <= 16'd3454;
      att_q        <= 20'd389120;
      tir_q        <= 1'b0;
      cos_q        <= 15'd12685;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        dir_q[i] <= '0;
      end
      flight_q     <= '0;
      bounce_q     <= '0;
      active_q     <= 1'b0;
      sample_q     <= '0;
      ax_q         <= '0;
      axis_sel_q   <= '0;
      found_q      <= 1'b0;
      best_q       <= '0;
      wall_q       <= '0;
      idx_ok_q     <= 1'b0;
      rom_addr_q   <= '0;
      acc_q        <= '0;
      res_status_q <= ST_IDLE;
      res_wall_q   <= '0;
      mul_a_q      <= '0;
      mul_b_q      <= '0;
      dv_rem_q     <= '0;
      dv_quo_q     <= '0;
      dv_dvs_q     <= '0;
      dv_cnt_q     <= '0;
      m_valid_q    <= 1'b0;
      m_status_q   <= '0;
      m_time_q     <= '0;
      m_bounce_q   <= '0;
      m_wall_q     <= '0;
    end else begin
      if (emit_fire) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;

      if (cfg_valid_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_LEN: len_q <= cfg_data_i[15:0];
          REG_WID: wid_q <= cfg_data_i[15:0];
          REG_THK: thk_q <= cfg_data_i[15:0];
          REG_RAD: rad_q <= cfg_data_i[15:0];
          REG_NSC: nsc_q <= cfg_data_i[15:0];
          REG_ATT: att_q <= cfg_data_i;
          REG_TIR: tir_q <= cfg_data_i[0];
          REG_COS: cos_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            res_wall_q <= '0;
            if (!s_axis_tuser) begin
              pos_q[0]     <= {1'b0, s_axis_tdata[15:0]};
              pos_q[1]     <= 17'($signed(s_axis_tdata[31:16]));
              pos_q[2]     <= 17'($signed(s_axis_tdata[47:32]));
              dir_q[0]     <= s_axis_tdata[63:48];
              dir_q[1]     <= s_axis_tdata[79:64];
              dir_q[2]     <= s_axis_tdata[95:80];
              flight_q     <= '0;
              bounce_q     <= '0;
              active_q     <= 1'b1;
              res_status_q <= ST_LAUNCHED;
              state_q      <= S_EMIT;
            end else if (!active_q) begin
              res_status_q <= ST_IDLE;
              state_q      <= S_EMIT;
            end else begin
              sample_q <= s_axis_tdata[111:96];
              ax_q     <= '0;
              found_q  <= 1'b0;
              state_q  <= S_AXIS;
            end
          end
        end
        S_AXIS: begin
          if (ax_ok) begin
            dv_rem_q <= '0;
            dv_quo_q <= DvdW'({mag, 14'b0});
            dv_dvs_q <= DvsW'(dm);
            dv_cnt_q <= CntW'(DvdW);
            state_q  <= S_DIV_AX;
          end else if (ax_q == 2'd2) begin
            state_q <= S_CHK;
          end else begin
            ax_q <= ax_q + 2'd1;
          end
        end
        S_DIV_AX: begin
          dv_rem_q <= dv_rem_d;
          dv_quo_q <= dv_quo_d;
          dv_cnt_q <= dv_cnt_q - CntW'(1);
          if (dv_cnt_q == CntW'(1)) begin
            if (t_new != '0 && (!found_q || t_new < best_q)) begin
              found_q    <= 1'b1;
              best_q     <= t_new;
              axis_sel_q <= ax_q;
              wall_q     <= wall_code;
            end
            if (ax_q == 2'd2) begin
              state_q <= S_CHK;
            end else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= S_AXIS;
            end
          end
        end
        S_CHK: begin
          if (!found_q) begin
            active_q     <= 1'b0;
            res_status_q <= ST_ABSORBED;
            state_q      <= S_EMIT;
          end else begin
            ax_q    <= '0;
            mul_a_q <= best_q;
            mul_b_q <= abs16(dir_q[0]);
            state_q <= S_MOV_W;
          end
        end
        S_MOV_W: state_q <= S_MOV_U;
        S_MOV_U: begin
          pos_q[ax_q] <= mv_new;
          if (ax_q == 2'd2) begin
            mul_b_q <= nsc_q;
            state_q <= S_TIME_W;
          end else begin
            mul_b_q <= abs16(dir_q[ax_q + 2'd1]);
            ax_q    <= ax_q + 2'd1;
            state_q <= S_MOV_W;
          end
        end
        S_TIME_W: state_q <= S_TIME_U;
        S_TIME_U: begin
          flight_q <= (time_sum[36:32] != '0) ? 32'hFFFF_FFFF : time_sum[31:0];
          mul_b_q  <= 16'(EXP_TABLE_DEPTH);
          state_q  <= S_IDX_W;
        end
        S_IDX_W: state_q <= S_IDX_U;
        S_IDX_U: begin
          dv_rem_q <= '0;
          dv_quo_q <= prod_q[DvdW-1:0];
          dv_dvs_q <= DvsW'({att_eff, 4'b0000});
          dv_cnt_q <= CntW'(DvdW);
          state_q  <= S_DIV_IX;
        end
        S_DIV_IX: begin
          dv_rem_q <= dv_rem_d;
          dv_quo_q <= dv_quo_d;
          dv_cnt_q <= dv_cnt_q - CntW'(1);
          if (dv_cnt_q == CntW'(1)) begin
            idx_ok_q   <= dv_quo_d < DvdW'(EXP_TABLE_DEPTH);
            rom_addr_q <= dv_quo_d[IdxW-1:0];
            state_q    <= S_ROM_W;
          end
        end
        S_ROM_W: state_q <= S_SURV;
        S_SURV: begin
          res_wall_q <= wall_q;
          if ({1'b0, sample_q} >= surv) begin
            active_q     <= 1'b0;
            res_status_q <= ST_ABSORBED;
            state_q      <= S_EMIT;
          end else if (wall_q == WallXPos) begin
            mul_a_q <= BestW'(abs17(pos_q[1]));
            mul_b_q <= abs17(pos_q[1]);
            state_q <= S_SQY_W;
          end else begin
            state_q <= S_TIR;
          end
        end
        S_SQY_W: state_q <= S_SQY_U;
        S_SQY_U: begin
          acc_q   <= prod_q[32:0];
          mul_a_q <= BestW'(abs17(pos_q[2]));
          mul_b_q <= abs17(pos_q[2]);
          state_q <= S_SQZ_W;
        end
        S_SQZ_W: state_q <= S_SQZ_U;
        S_SQZ_U: begin
          acc_q   <= acc_q + prod_q[32:0];
          mul_a_q <= BestW'(rad_q);
          mul_b_q <= rad_q;
          state_q <= S_SQR_W;
        end
        S_SQR_W: state_q <= S_SQR_U;
        S_SQR_U: begin
          if ({13'b0, acc_q} <= prod_q) begin
            active_q     <= 1'b0;
            res_status_q <= ST_DETECTED;
            state_q      <= S_EMIT;
          end else begin
            state_q <= S_TIR;
          end
        end
        S_TIR: begin
          if (tir_q && abs16(dir_sel) > {1'b0, cos_q}) begin
            active_q     <= 1'b0;
            res_status_q <= ST_ESCAPED;
          end else begin
            dir_q[axis_sel_q] <= dir_ref;
            bounce_q          <= bounce_inc;
            if (bounce_inc >= 10'(MAX_BOUNCES)) begin
              active_q     <= 1'b0;
              res_status_q <= ST_LIMIT;
            end else begin
              res_status_q <= ST_REFLECTED;
            end
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            m_status_q <= res_status_q;
            m_time_q   <= flight_q;
            m_bounce_q <= bounce_q;
            m_wall_q   <= res_wall_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
